>>> rtl/core/bdac_pkg.sv
// bdac_pkg: shared constants, types and the digit adjust function
// for the binary to decimal ascii unit
// no dependencies
package bdac_pkg;

    // parameter defaults
    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_MAX_DIGITS = 10;

    // character encoding
    localparam int          CHAR_W      = 6;
    localparam int          DIGIT_W     = 4;
    localparam logic [5:0]  ASCII_ZERO  = 6'd48;
    localparam logic [5:0]  ASCII_MINUS = 6'd45;
    localparam logic [3:0]  DIGIT_NINE  = 4'd9;

    // handoff from converter to character emitter
    typedef struct packed {
        logic valid;
        logic neg;
        logic ovf;
    } t_conv_ctl;

    // add-3 correction of one bcd digit before it is doubled
    function automatic logic [3:0] dabble_adj(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= 4'd5) ? (d + 4'd3) : d;
        return r;
    endfunction

endpackage

>>> rtl/core/bdac_dabble.sv
// bdac_dabble: bit-serial shift-and-add-3 binary to bcd converter
// takes the sign off in signed mode and holds the bcd result for the emitter
// depends on bdac_pkg
module bdac_dabble #(
    parameter int VALUE_BITS = bdac_pkg::DEF_VALUE_BITS,
    parameter int MAX_DIGITS = bdac_pkg::DEF_MAX_DIGITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [VALUE_BITS-1:0]                  i_value,
    input  logic                                   i_mode,
    output bdac_pkg::t_conv_ctl                    o_ctl,
    input  logic                                   i_ctl_ready,
    output logic [MAX_DIGITS*bdac_pkg::DIGIT_W-1:0] o_bcd
);

    localparam int BCD_W = MAX_DIGITS * bdac_pkg::DIGIT_W;
    localparam int CNT_W = $clog2(VALUE_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

    t_state               r_state;
    logic [VALUE_BITS-1:0] r_bin;
    logic [BCD_W-1:0]     r_bcd;
    logic [CNT_W-1:0]     r_bit_cnt;
    logic                 r_neg;
    logic                 r_ovf;

    logic [BCD_W-1:0]      n_adj;
    logic                  n_neg;
    logic [VALUE_BITS-1:0] n_mag;

    // sign detect and magnitude of the incoming beat
    always_comb begin
        n_neg = i_mode & i_value[VALUE_BITS-1];
        n_mag = n_neg ? VALUE_BITS'(~i_value + 1'b1) : i_value;
    end

    // add-3 on every digit, independent of each other
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            n_adj[d*bdac_pkg::DIGIT_W +: bdac_pkg::DIGIT_W] =
                bdac_pkg::dabble_adj(r_bcd[d*bdac_pkg::DIGIT_W +: bdac_pkg::DIGIT_W]);
        end
    end

    // sequencer, one binary bit shifted in per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_bit_cnt <= '0;
            r_neg     <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_bin     <= n_mag;
                        r_bcd     <= '0;
                        r_neg     <= n_neg;
                        r_ovf     <= 1'b0;
                        r_bit_cnt <= CNT_W'(VALUE_BITS - 1);
                        r_state   <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    // a set top bit would leave the digit register: too many digits
                    r_ovf     <= r_ovf | n_adj[BCD_W-1];
                    r_bcd     <= {n_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
                    r_bin     <= {r_bin[VALUE_BITS-2:0], 1'b0};
                    r_bit_cnt <= r_bit_cnt - 1'b1;
                    if (r_bit_cnt == '0) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (i_ctl_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_ctl.valid = (r_state == ST_HOLD);
    assign o_ctl.neg   = r_neg;
    assign o_ctl.ovf   = r_ovf;
    assign o_bcd       = r_bcd;

endmodule

>>> rtl/core/bdac_emit.sv
// bdac_emit: walks the bcd digits from the top, drops leading zeros
// and sends '-' and the digit characters one beat at a time
// depends on bdac_pkg
module bdac_emit #(
    parameter int MAX_DIGITS = bdac_pkg::DEF_MAX_DIGITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  bdac_pkg::t_conv_ctl                     i_ctl,
    output logic                                    o_ctl_ready,
    input  logic [MAX_DIGITS*bdac_pkg::DIGIT_W-1:0] i_bcd,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [bdac_pkg::CHAR_W-1:0]             o_ascii_char,
    output logic                                    o_last
);

    localparam int BCD_W = MAX_DIGITS * bdac_pkg::DIGIT_W;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    t_state                       r_state;
    logic [BCD_W-1:0]             r_bcd;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_neg;
    logic                         r_ovf;
    logic                         r_valid;
    logic [bdac_pkg::CHAR_W-1:0]  r_char;
    logic                         r_last;

    logic [bdac_pkg::DIGIT_W-1:0] n_top;
    logic                         n_free;
    logic                         n_load;

    assign n_top  = r_bcd[BCD_W-1 -: bdac_pkg::DIGIT_W];
    assign n_free = !r_valid || i_ready;
    // a character goes into the output register this cycle
    assign n_load = n_free && ((r_state == ST_SIGN) || (r_state == ST_EMIT));

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_neg   <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            // output beat valid: set on a new character, cleared once taken
            if (n_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_ctl.valid) begin
                        r_bcd   <= i_bcd;
                        r_neg   <= i_ctl.neg;
                        r_ovf   <= i_ctl.ovf;
                        r_cnt   <= CNT_W'(MAX_DIGITS);
                        r_state <= ST_SKIP;
                    end
                end
                ST_SKIP: begin
                    // leading zero drop, always keeping the units digit
                    priority if (!r_ovf && (r_cnt > CNT_W'(1)) && (n_top == '0)) begin
                        r_bcd <= {r_bcd[BCD_W-bdac_pkg::DIGIT_W-1:0],
                                  {bdac_pkg::DIGIT_W{1'b0}}};
                        r_cnt <= r_cnt - 1'b1;
                    end else if (r_neg) begin
                        r_state <= ST_SIGN;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_SIGN: begin
                    if (n_free) begin
                        r_char  <= bdac_pkg::ASCII_MINUS;
                        r_last  <= 1'b0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (n_free) begin
                        r_char  <= bdac_pkg::ASCII_ZERO + {2'b00, n_top};
                        r_last  <= (r_cnt == CNT_W'(1));
                        r_bcd   <= {r_bcd[BCD_W-bdac_pkg::DIGIT_W-1:0],
                                    {bdac_pkg::DIGIT_W{1'b0}}};
                        r_cnt   <= r_cnt - 1'b1;
                        if (r_cnt == CNT_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ctl_ready  = (r_state == ST_IDLE);
    assign o_valid      = r_valid;
    assign o_ascii_char = r_char;
    assign o_last       = r_last;

endmodule

>>> rtl/core/binary_to_decimal_ascii_unit.sv
// binary_to_decimal_ascii_unit: top level, converter plus character emitter
// usage
//   input channel i_valid/o_ready carries i_value and i_mode (0 unsigned,
//   1 two's complement); output channel o_valid/i_ready carries one ascii
//   character per beat in o_ascii_char, o_last set on the final one
//   text is most significant digit first, no leading zeros, '0' for zero,
//   and '-' ahead of the magnitude for a negative signed value
// timing
//   the converter shifts one value bit per cycle and then holds the result
//   until the emitter takes it; the emitter drops one leading zero per cycle
//   (up to MAX_DIGITS-1) and sends one character per cycle after that while
//   the receiver is ready
//   a new value is converted while the previous one is still being emitted
// reset and stall
//   synchronous active low reset empties both stages and drops o_valid
//   a stalled receiver holds the output register; the emitter and then the
//   converter wait, and o_ready stays low until the converter is free
// depends on bdac_pkg, bdac_dabble, bdac_emit
module binary_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = bdac_pkg::DEF_VALUE_BITS,
    parameter int MAX_DIGITS = bdac_pkg::DEF_MAX_DIGITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [VALUE_BITS-1:0]       i_value,
    input  logic                        i_mode,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bdac_pkg::CHAR_W-1:0] o_ascii_char,
    output logic                        o_last
);

    bdac_pkg::t_conv_ctl                     w_ctl;
    logic                                    w_ctl_ready;
    logic [MAX_DIGITS*bdac_pkg::DIGIT_W-1:0] w_bcd;

    // bit-serial conversion to bcd
    bdac_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .i_mode      (i_mode),
        .o_ctl       (w_ctl),
        .i_ctl_ready (w_ctl_ready),
        .o_bcd       (w_bcd)
    );

    // digit-serial character output
    bdac_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_ctl_ready  (w_ctl_ready),
        .i_bcd        (w_bcd),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last)
    );

    // characters are only '-' or a decimal digit
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ascii_char == bdac_pkg::ASCII_MINUS) ||
                    ((o_ascii_char >= bdac_pkg::ASCII_ZERO) &&
                     (o_ascii_char <= bdac_pkg::ASCII_ZERO + {2'b00, bdac_pkg::DIGIT_NINE})))
        else $error("illegal character on output");

    // the sign never ends a number
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_ascii_char == bdac_pkg::ASCII_MINUS)) |-> !o_last)
        else $error("minus flagged as last character");

    // a converted value waits until the emitter takes it
    a_handoff_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.valid && !w_ctl_ready) |=> w_ctl.valid)
        else $error("converter dropped a result before handoff");

    // the converter is busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted twice in a row");

endmodule
